// File: src/ipfc_pkg.sv
package ipfc_pkg;

	localparam int NUM_BUCKETS = 16;
	localparam int WAYS = 4;
	localparam int ENTRIES = NUM_BUCKETS * WAYS;
	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W = 64;
	localparam int CNT_W = 32;
	// One memory word holds the valid mark, the count and the key.
	localparam int WORD_W = 1 + CNT_W + KEY_W;
	localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
	localparam logic [31:0] HASH_MUL_B = 32'd2246822519;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic valid;
		logic [CNT_W-1:0] count;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [BKT_W-1:0] bucket;
	} hash_res_t;

endpackage

// File: src/ipfc_ram.sv
module ipfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/ipfc_hash.sv
module ipfc_hash import ipfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	output logic        done,
	output hash_res_t   res
);

	// Registered steps: two 32-bit products, a shift-and-xor mix, then the 64-bit product in two halves.
	logic [3:0]  ph_q;
	logic [31:0] a_q, b_q;
	logic [63:0] h1_q;
	logic [63:0] lo_q;
	logic [31:0] hi_q;
	logic [63:0] key_q;
	logic [63:0] h0, h2, h3;
	logic [63:0] pa, pb;

	assign pa = {32'd0, src_ip} * {32'd0, HASH_MUL_A};
	assign pb = {32'd0, dst_ip} * {32'd0, HASH_MUL_B};
	assign h0 = {32'd0, a_q} ^ {31'd0, b_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= '0;
		end else begin
			ph_q <= {ph_q[2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= pa[31:0];
			b_q   <= pb[31:0];
			key_q <= {dst_ip, src_ip};
		end
		if (ph_q[0]) begin
			h1_q <= h0 ^ (h0 >> 16);
		end
		if (ph_q[1]) begin
			// Low half times the multiplier is a full 64-bit partial product.
			lo_q <= {32'd0, h1_q[31:0]} * {32'd0, HASH_MUL_A};
		end
		if (ph_q[2]) begin
			hi_q <= 32'(h1_q[63:32] * HASH_MUL_A);
		end
	end

	assign h2 = lo_q + {hi_q, 32'd0};
	assign h3 = h2 ^ (h2 >> 16);
	assign done = ph_q[3];
	assign res.key = key_q;
	assign res.bucket = BKT_W'(h3 % 64'(NUM_BUCKETS));

endmodule

// File: src/ip_pair_flow_counter.sv
// Flow counter keyed by a source and destination IPv4 pair. Each beat is hashed
// to one of NUM_BUCKETS buckets and the bucket's WAYS ways, held in one
// single-port-read memory, are read one way a cycle, then the chosen way is
// written back if the key hit or a free way was found. Each item passes through
// the hash, the way reads, the write and the load of the output register; one
// item is handled at a time, and a new beat is accepted only back in idle. The
// result waits in an output register while the next beat is accepted and
// processed; a later result that finds the register still held waits until it
// is taken.
// After reset a clearing pass writes every entry invalid; no beat is accepted
// during it.
module ip_pair_flow_counter import ipfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pair_count,
	output logic        new_flow,
	output logic        table_full,
	output logic [3:0]  bucket_index,
	output logic [31:0] total_packets
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_WRITE = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic [ADDR_W:0] clr_q;
	logic [WAY_W:0] rd_q;
	logic [WAY_W:0] chk_q;
	logic rd_vld_q;
	logic hit_q, free_q;
	logic [WAY_W-1:0] hit_way_q, free_way_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] total_q;
	hash_res_t hres_q;
	logic hash_start, hash_done;
	hash_res_t hres;
	logic we;
	logic [ADDR_W-1:0] waddr, raddr;
	entry_t wentry, rentry;
	logic [WORD_W-1:0] rword;
	logic [WAY_W-1:0] rway;

	assign in_ready = (state_q == ST_IDLE);
	assign hash_start = in_valid && in_ready;
	assign rway = WAY_W'(rd_q);

	ipfc_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(hash_start),
		.src_ip(src_ip), .dst_ip(dst_ip), .done(hash_done), .res(hres)
	);

	assign raddr = ADDR_W'(hres_q.bucket * WAYS + rway);
	assign rentry = entry_t'(rword);

	always_comb begin
		we = 1'b0;
		waddr = ADDR_W'(hres_q.bucket * WAYS + (hit_q ? hit_way_q : free_way_q));
		wentry.valid = 1'b1;
		wentry.key = hres_q.key;
		wentry.count = hit_q ? ((hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + 1'b1)
			: CNT_W'(1);
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			waddr = clr_q[ADDR_W-1:0];
			wentry = '0;
		end else if (state_q == ST_WRITE) begin
			we = hit_q || free_q;
		end
	end

	ipfc_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(WORD_W'(wentry)),
		.raddr(raddr), .rdata(rword)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_q      <= '0;
			chk_q     <= '0;
			rd_vld_q  <= 1'b0;
			out_valid <= 1'b0;
			total_q   <= '0;
		end else begin
			if (out_valid && out_ready && state_q != ST_OUT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ADDR_W+1)'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (hash_start) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q  <= ST_READ;
						rd_q     <= '0;
						chk_q    <= '0;
						rd_vld_q <= 1'b0;
					end
				end
				ST_READ: begin
					rd_vld_q <= (rd_q < (WAY_W+1)'(WAYS));
					if (rd_q < (WAY_W+1)'(WAYS)) begin
						rd_q <= rd_q + 1'b1;
					end
					if (rd_vld_q) begin
						chk_q <= chk_q + 1'b1;
						if (chk_q == (WAY_W+1)'(WAYS - 1)) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (hit_q || free_q) begin
						total_q <= (total_q == CNT_MAX) ? total_q : total_q + 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hash_done) begin
			hres_q <= hres;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end
		if (state_q == ST_READ && rd_vld_q) begin
			if (rentry.valid) begin
				if (!hit_q && rentry.key == hres_q.key) begin
					hit_q     <= 1'b1;
					hit_way_q <= WAY_W'(chk_q);
					hit_cnt_q <= rentry.count;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_way_q <= WAY_W'(chk_q);
			end
		end
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			pair_count   <= (hit_q || free_q) ? wentry.count : '0;
			new_flow     <= !hit_q && free_q;
			table_full   <= !hit_q && !free_q;
			bucket_index <= 4'(hres_q.bucket);
			total_packets <= total_q;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready) else $error("beat accepted during clear");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(new_flow && table_full)) else $error("new and full together");
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> pair_count == '0) else $error("full with count");
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> total_q >= $past(total_q)) else $error("total fell");
`endif

endmodule
